### design/vlbp_pkg.sv
// shared types and constants for the variable length bit packer
// no dependencies

package vlbp_pkg;

    // field widths and limits
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned REM_W       = 7;
    localparam int unsigned TAKE_W      = 4;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 8'd64;

    // request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // input request
    typedef struct packed {
        logic               req_type;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] num_bits;
    } vlbp_in_t;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              status;
        logic              last;
    } vlbp_out_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } vlbp_state_t;

endpackage

### design/variable_length_bit_packer.sv
// variable length bit packer top level: sequencer and shared chunk unit
// depends on vlbp_pkg

// A write request appends the low num_bits bits of value (1 to 64) to a
// byte stream, packing from the top of each byte; every completed byte comes
// out as its own result, the final one marked with last. The shared chunk
// unit places one run of bits into the current byte per cycle, except while a
// finished byte is held by m_ready; a write is packed as one chunk per byte
// it touches (1 to 9). Flush requests and bad-count requests are handled in
// the accept cycle itself. The block takes no new request while a write is
// being packed.

module variable_length_bit_packer
    import vlbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  vlbp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output vlbp_out_t m_data
);

    vlbp_state_t        state_reg,     state_next;
    logic [BYTE_W-1:0]  partial_reg,   partial_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [REM_W-1:0]   rem_reg,       rem_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    vlbp_out_t          out_reg,       out_next;
    logic               out_valid_reg, out_valid_next;

    logic              out_free;
    logic              accept;
    logic              step_en;
    logic              bad_count;
    logic [TAKE_W-1:0] room;
    logic [TAKE_W-1:0] take;
    logic [TAKE_W-1:0] shift;
    logic [TAKE_W-1:0] pos_sum;
    logic [BYTE_W:0]   mask;
    logic [BYTE_W-1:0] chunk;
    logic [BYTE_W-1:0] byte_new;
    logic [REM_W-1:0]  rem_after;

    // output register free when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign step_en  = (state_reg == ST_WORK) && out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign bad_count = (s_data.num_bits == '0) || (s_data.num_bits > MAX_COUNT);

    // shared chunk unit: place up to one byte's room of bits
    always_comb begin
        room      = TAKE_W'(BYTE_W) - {1'b0, pos_reg};
        take      = (rem_reg < REM_W'(room)) ? rem_reg[TAKE_W-1:0] : room;
        mask      = (9'd1 << take) - 9'd1;
        chunk     = value_reg[BYTE_W-1:0] & mask[BYTE_W-1:0];
        shift     = room - take;
        byte_new  = partial_reg | BYTE_W'(chunk << shift[POS_W-1:0]);
        pos_sum   = {1'b0, pos_reg} + take;
        rem_after = rem_reg - REM_W'(take);
    end

    // sequencer next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        partial_next   = partial_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        value_next     = value_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == REQ_FLUSH) begin
                        if (pos_reg != '0) begin
                            out_next.byte_out = partial_reg;
                            out_next.status   = STATUS_OK;
                            out_next.last     = 1'b1;
                            out_valid_next    = 1'b1;
                            partial_next      = '0;
                            pos_next          = '0;
                        end
                    end else if (bad_count) begin
                        out_next.byte_out = '0;
                        out_next.status   = STATUS_ERR;
                        out_next.last     = 1'b1;
                        out_valid_next    = 1'b1;
                    end else begin
                        value_next = s_data.value;
                        rem_next   = REM_W'(s_data.num_bits);
                        state_next = ST_WORK;
                    end
                end
            end
            ST_WORK: begin
                if (step_en) begin
                    value_next = value_reg >> take;
                    rem_next   = rem_after;
                    if (pos_sum == TAKE_W'(BYTE_W)) begin
                        out_next.byte_out = byte_new;
                        out_next.status   = STATUS_OK;
                        out_next.last     = (rem_after < REM_W'(BYTE_W));
                        out_valid_next    = 1'b1;
                        partial_next      = '0;
                        pos_next          = '0;
                    end else begin
                        partial_next = byte_new;
                        pos_next     = pos_sum[POS_W-1:0];
                    end
                    if (rem_after == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            partial_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        value_reg <= value_next;
        out_reg   <= out_next;
    end

endmodule

### tb/sv/variable_length_bit_packer_tb.sv
// self-checking testbench for the variable length bit packer: directed and random requests
// depends on vlbp_pkg and variable_length_bit_packer
`timescale 1ns / 1ps

module variable_length_bit_packer_tb;
    import vlbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned RANDOM_REQS = 460;
    localparam int unsigned HOLD_AFTER = 120;
    localparam int unsigned HOLD_CYCLES = 500;
    localparam int unsigned MAX_WAIT = 11;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    vlbp_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    vlbp_out_t m_data;

    // request stream and the bytes it should produce
    vlbp_in_t  req_q[$];
    vlbp_out_t byte_q[$];

    // packer state as the predictor sees it
    logic [BYTE_W-1:0] fill_byte = '0;
    int unsigned       fill_pos = 0;

    int unsigned total_n = 0;
    int unsigned taken_n = 0;
    int unsigned seen_n = 0;
    int unsigned fail_n = 0;
    int unsigned cycle_n = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    // sender and receiver pacing, private to their own processes
    int unsigned tx_gap = 0;
    int unsigned tx_count = 0;
    bit          tx_burst = 1'b0;
    int unsigned rx_wait = 0;
    int unsigned rx_count = 0;
    bit          rx_burst = 1'b0;

    variable_length_bit_packer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void add_write(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] n);
        vlbp_in_t rq;
        rq.req_type = REQ_WRITE;
        rq.value = v;
        rq.num_bits = n;
        req_q.push_back(rq);
    endfunction

    function automatic void add_flush(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] n);
        vlbp_in_t rq;
        rq.req_type = REQ_FLUSH;
        rq.value = v;
        rq.num_bits = n;
        req_q.push_back(rq);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // work out the bytes a request completes and update the packer state
    function automatic void pack_request(input vlbp_in_t rq);
        vlbp_out_t   done_q[$];
        vlbp_out_t   r;
        logic [7:0]  chunk;
        int unsigned used;
        int unsigned room;
        int unsigned take;
        if (rq.req_type == REQ_FLUSH) begin
            if (fill_pos != 0) begin
                r.byte_out = fill_byte;
                r.status = STATUS_OK;
                r.last = 1'b1;
                byte_q.push_back(r);
                fill_byte = '0;
                fill_pos = 0;
            end
            return;
        end
        if (rq.num_bits == '0 || rq.num_bits > MAX_COUNT) begin
            r.byte_out = '0;
            r.status = STATUS_ERR;
            r.last = 1'b1;
            byte_q.push_back(r);
            return;
        end
        used = 0;
        while (used < rq.num_bits) begin
            room = BYTE_W - fill_pos;
            take = rq.num_bits - used;
            if (take > room) begin
                take = room;
            end
            chunk = 8'((rq.value >> used) & ((64'd1 << take) - 64'd1));
            fill_byte = fill_byte | (chunk << (room - take));
            fill_pos += take;
            used += take;
            if (fill_pos == BYTE_W) begin
                r.byte_out = fill_byte;
                r.status = STATUS_OK;
                r.last = 1'b0;
                done_q.push_back(r);
                fill_byte = '0;
                fill_pos = 0;
            end
        end
        for (int i = 0; i < done_q.size(); i++) begin
            r = done_q[i];
            r.last = (i == done_q.size() - 1);
            byte_q.push_back(r);
        end
    endfunction

    // sender: offer queued requests with a random gap before each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = draw_wait(1'b0);
        end else if (!s_valid || s_ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                s_data <= req_q.pop_front();
                s_valid <= 1'b1;
                tx_count++;
                if (tx_count % 40 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                end
                tx_gap = draw_wait(tx_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = draw_wait(1'b0);
        end else begin
            if (s_valid && s_ready) begin
                pack_request(s_data);
                taken_n <= taken_n + 1;
            end
            if (m_valid && m_ready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected result: byte_out %0h status %0b last %0b",
                           m_data.byte_out, m_data.status, m_data.last);
                    fail_n++;
                end else begin
                    vlbp_out_t want;
                    want = byte_q.pop_front();
                    if (m_data.byte_out !== want.byte_out) begin
                        $error("byte_out: expected %0h, got %0h", want.byte_out, m_data.byte_out);
                        fail_n++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0b, got %0b", want.status, m_data.status);
                        fail_n++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_data.last);
                        fail_n++;
                    end
                end
                seen_n <= seen_n + 1;
                rx_count++;
                if (rx_count % 40 == 0) begin
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                rx_wait = draw_wait(rx_burst);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // one long receiver hold-off so the packer backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && seen_n >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("[variable_length_bit_packer] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        // directed: error counts, full-width writes, byte boundaries, flushes
        add_flush(rand_value(), 8'd5);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd65);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd64);
        add_write(64'h0, 8'd64);
        add_write(64'h1, 8'd1);
        add_flush(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        add_write(64'h5, 8'd3);
        add_write(64'h7F, 8'd7);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd64);
        add_write(64'h0123_4567_89AB_CDEF, 8'd128);
        add_flush(64'h0, 8'd0);
        add_write(64'hA5, 8'd8);
        add_write(64'hFFFF_FFFF_FFFF_FFF3, 8'd5);
        add_write(64'h2, 8'd3);
        add_write(64'h1, 8'd1);
        add_write(64'h8000_0000_0000_0001, 8'd64);
        add_flush(64'h0, 8'd64);
        add_write(64'hFFFF_FFFF_FFFF_FFFF, 8'd4);
        add_flush(64'h0, 8'd0);

        // random: mostly well-formed writes, some flushes and bad counts
        repeat (RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 19))
                    0: add_write(rand_value(), 8'd64);
                    1, 2, 3: add_write(rand_value(), 8'($urandom_range(17, 63)));
                    default: add_write(rand_value(), 8'($urandom_range(1, 16)));
                endcase
            end else if (pick < 85) begin
                add_flush(rand_value(), 8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                add_write(rand_value(), 8'd0);
            end else begin
                add_write(rand_value(), 8'($urandom_range(65, 255)));
            end
        end
        total_n = req_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (taken_n != total_n) @(posedge aclk);
        while (byte_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_n == 0) begin
            $display("[variable_length_bit_packer] OK");
        end else begin
            $display("[variable_length_bit_packer] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/vlbp_pkg.sv
design/variable_length_bit_packer.sv
tb/sv/variable_length_bit_packer_tb.sv
